// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types for the point-in-polygon crossing-number block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Command class decided by the front end
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_RESTART = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  // Back-end sequencer, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  typedef struct packed {
    logic idle;
    logic walking;
    logic draining;
  } bk_stat_t;

endpackage

// ===== rtl/pip_ram.sv =====
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pip_front.sv =====
// ----------------------------------------------------------------------------
// pip_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pip_front
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         mode_i,
  input  logic                         start_polygon_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         cmd_valid_o,
  output op_e                          cmd_op_o,
  output logic signed [COORD_BITS-1:0] cmd_x_o,
  output logic signed [COORD_BITS-1:0] cmd_y_o,
  input  logic                         cmd_pop_i
);

  op_e                          op_q [2];
  logic signed [COORD_BITS-1:0] x_q  [2];
  logic signed [COORD_BITS-1:0] y_q  [2];
  logic                         wptr_q, wptr_d;
  logic                         rptr_q, rptr_d;
  logic [1:0]                   fill_q, fill_d;
  logic                         push;
  logic                         pop;
  op_e                          op_in;

  assign busy_o = (fill_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = cmd_pop_i && (fill_q != 2'd0);

  always_comb begin
    if (mode_i) begin
      op_in = OP_QUERY;
    end else if (start_polygon_i) begin
      op_in = OP_RESTART;
    end else begin
      op_in = OP_APPEND;
    end
  end

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (pop) begin
      rptr_d = ~rptr_q;
    end
    case ({push, pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wptr_q] <= op_in;
      x_q[wptr_q]  <= coord_x_i;
      y_q[wptr_q]  <= coord_y_i;
    end
  end

  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_op_o    = op_q[rptr_q];
  assign cmd_x_o     = x_q[rptr_q];
  assign cmd_y_o     = y_q[rptr_q];

endmodule

// ===== rtl/pip_back.sv =====
// ----------------------------------------------------------------------------
// pip_back
// Executes queued commands: stores vertices, walks the edges for a query.
// ----------------------------------------------------------------------------
module pip_back
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  op_e                          cmd_op_i,
  input  logic signed [COORD_BITS-1:0] cmd_x_i,
  input  logic signed [COORD_BITS-1:0] cmd_y_i,
  output logic                         cmd_pop_o,
  output logic                         res_valid_o,
  output logic                         inside_res_o,
  output logic                         vertices_dropped_o,
  output bk_stat_t                     stat_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  state_e                       state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         ovf_q, ovf_d;
  logic signed [COORD_BITS-1:0] px_q, px_d;
  logic signed [COORD_BITS-1:0] py_q, py_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic                         rd_v_q, rd_v_d;
  logic                         first_q, first_d;
  logic                         par_q, par_d;
  logic                         res_v_q, res_v_d;
  logic                         inside_q, inside_d;
  logic                         drop_q, drop_d;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [CW-1:0]                base;
  logic [AW-1:0]                last_addr;
  logic [2*COORD_BITS-1:0]      rdata;

  // edge pipeline
  logic signed [COORD_BITS-1:0] x0_q, y0_q;
  logic signed [COORD_BITS-1:0] x1, y1;
  logic                         crossing;
  logic                         a_v_q, a_up_q;
  logic signed [DW-1:0]         dx0_q, dy_q, ey_q, ex_q;
  logic                         b_v_q, b_up_q;
  logic signed [PW-1:0]         p1_q, p2_q;
  logic                         hit;

  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({cmd_x_i, cmd_y_i}),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign last_addr = AW'(cnt_q - CW'(1));
  assign hit       = b_up_q ? (p1_q < p2_q) : (p1_q > p2_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    px_d      = px_q;
    py_d      = py_q;
    addr_d    = addr_q;
    rd_v_d    = 1'b0;
    first_d   = first_q;
    par_d     = par_q ^ (b_v_q & hit);
    res_v_d   = 1'b0;
    inside_d  = inside_q;
    drop_d    = drop_q;
    we        = 1'b0;
    cmd_pop_o = 1'b0;
    base      = (cmd_op_i == OP_RESTART) ? '0 : cnt_q;
    waddr     = base[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_op_i)
            OP_APPEND, OP_RESTART: begin
              if (cmd_op_i == OP_RESTART) begin
                ovf_d = 1'b0;
              end
              if (base < CW'(MAX_VERTICES)) begin
                we    = 1'b1;
                cnt_d = base + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_QUERY: begin
              px_d  = cmd_x_i;
              py_d  = cmd_y_i;
              par_d = 1'b0;
              if (cnt_q < CW'(2)) begin
                res_v_d  = 1'b1;
                inside_d = 1'b0;
                drop_d   = ovf_q;
              end else begin
                addr_d  = '0;
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // one vertex read per cycle
        rd_v_d  = 1'b1;
        first_d = (addr_q == '0);
        if (addr_q == last_addr) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !a_v_q && !b_v_q) begin
          res_v_d  = 1'b1;
          inside_d = par_q;
          drop_d   = ovf_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      addr_q  <= '0;
      rd_v_q  <= 1'b0;
      first_q <= 1'b0;
      par_q   <= 1'b0;
      res_v_q <= 1'b0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      addr_q  <= addr_d;
      rd_v_q  <= rd_v_d;
      first_q <= first_d;
      par_q   <= par_d;
      res_v_q <= res_v_d;
      a_v_q   <= rd_v_q && !first_q && crossing;
      b_v_q   <= a_v_q;
    end
  end

  // stage A: edge from the previous vertex to the one just read
  assign x1       = rdata[2*COORD_BITS-1:COORD_BITS];
  assign y1       = rdata[COORD_BITS-1:0];
  assign crossing = ((y0_q <= py_q) && (y1 > py_q)) || ((y0_q > py_q) && (y1 <= py_q));

  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    inside_q <= inside_d;
    drop_q   <= drop_d;
    if (rd_v_q) begin
      x0_q <= x1;
      y0_q <= y1;
    end
    // upward edge when the previous vertex is at or below the point
    a_up_q <= (y0_q <= py_q);
    dx0_q  <= DW'(px_q) - DW'(x0_q);
    dy_q   <= DW'(y1) - DW'(y0_q);
    ey_q   <= DW'(py_q) - DW'(y0_q);
    ex_q   <= DW'(x1) - DW'(x0_q);
    // stage B: exact cross products
    b_up_q <= a_up_q;
    p1_q   <= PW'(dx0_q) * PW'(dy_q);
    p2_q   <= PW'(ey_q) * PW'(ex_q);
  end

  assign res_valid_o        = res_v_q;
  assign inside_res_o       = inside_q;
  assign vertices_dropped_o = drop_q;

  assign stat_o.idle     = (state_q == ST_IDLE);
  assign stat_o.walking  = (state_q == ST_WALK);
  assign stat_o.draining = (state_q == ST_DRAIN);

endmodule

// ===== rtl/point_in_polygon_crossing_top.sv =====
// A vertex append is written to the vertex RAM in the cycle it leaves the queue; a
// query over n >= 2 stored vertices walks the vertex RAM and drains edge stages A and
// B before its result is given; if n < 2 the result comes in the cycle after it leaves the queue.
// Throughput: one vertex read per cycle from the vertex RAM during a query walk;
// appends go at one per cycle while the back end is idle. The receiver cannot stall.
// Reset clears the vertex count, overflow flag, queue and sequencer, not the vertex RAM.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_top
// Crossing-number point-in-polygon test over a stored vertex list.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_top
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode_i,
  input  logic                         start_polygon_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         valid_o,
  output logic                         inside_res_o,
  output logic                         vertices_dropped_o
);

  logic                         cmd_valid;
  op_e                          cmd_op;
  logic signed [COORD_BITS-1:0] cmd_x;
  logic signed [COORD_BITS-1:0] cmd_y;
  logic                         cmd_pop;
  bk_stat_t                     bk_stat;

  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .mode_i          (mode_i),
    .start_polygon_i (start_polygon_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_op_o        (cmd_op),
    .cmd_x_o         (cmd_x),
    .cmd_y_o         (cmd_y),
    .cmd_pop_i       (cmd_pop)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_valid_i        (cmd_valid),
    .cmd_op_i           (cmd_op),
    .cmd_x_i            (cmd_x),
    .cmd_y_i            (cmd_y),
    .cmd_pop_o          (cmd_pop),
    .res_valid_o        (valid_o),
    .inside_res_o       (inside_res_o),
    .vertices_dropped_o (vertices_dropped_o),
    .stat_o             (bk_stat)
  );

`ifndef SYNTH
  // results come only from an idle short query or the end of a drain
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(bk_stat.idle || bk_stat.draining))
    else $error("result without a finished query");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> bk_stat.idle)
    else $error("queue popped while back end busy");

  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.walking |=> (bk_stat.walking || bk_stat.draining))
    else $error("edge walk left without draining");

  a_no_res_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(bk_stat.walking) |-> !valid_o)
    else $error("result during edge walk");
`endif

endmodule
